// ===== rtl/tpe_pkg.sv =====
// Shared types and constants for the triangle plane equation block.
package tpe_pkg;

  localparam int VERTEX_DEPTH = 4096;
  localparam int ADDR_W       = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;

  localparam int IDX_W   = 12;
  localparam int COORD_W = 32;
  localparam int VERT_W  = 3 * COORD_W;
  localparam int EDGE_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * EDGE_W;
  localparam int CROSS_W = PROD_W + 1;
  localparam int MAG_W   = PROD_W;
  localparam int LEN_W   = 7;
  localparam int SC_W    = 30;
  localparam int SHF_W   = MAG_W + SC_W;
  localparam int SQ_W    = 2 * SC_W;
  localparam int SUM_W   = SQ_W + 2;
  localparam int SQRT_W  = 64;
  localparam int ISQRT_STEPS = 32;
  localparam int ROOT_W  = 31;
  localparam int QUO_W   = 31;
  localparam int REM_W   = SQ_W + 2;
  localparam int NRM_W   = 32;
  localparam int DP_W    = NRM_W + COORD_W;
  localparam int DOT_W   = DP_W + 2;
  localparam int FIN_W   = DOT_W + 1;
  localparam int CHUNK_W = 8;
  localparam int NCHUNK  = (MAG_W + CHUNK_W - 1) / CHUNK_W;
  localparam int CLEN_W  = 4;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_FACE = 1'b1;

  localparam logic signed [FIN_W-1:0] OFS_HALF = FIN_W'(1) << (SC_W - 1);
  localparam logic signed [FIN_W-1:0] OFS_MAX  = FIN_W'(32'sh7FFF_FFFF);
  localparam logic signed [FIN_W-1:0] OFS_MIN  = FIN_W'(32'sh8000_0000);

  typedef logic [ADDR_W-1:0]              addr_t;
  typedef logic signed [COORD_W-1:0]      coord_t;
  typedef logic [2:0][SC_W-1:0]           sc_vec_t;
  typedef logic [2:0][QUO_W-1:0]          quo_vec_t;
  typedef logic [2:0][REM_W-1:0]          rem_vec_t;

  // Sideband that rides along every stage of the face path.
  typedef struct packed {
    logic       vld;
    logic       last;
    logic       degen;
    logic [2:0] neg;
    coord_t     ax;
    coord_t     ay;
    coord_t     az;
  } side_t;

endpackage

// ===== rtl/indexed_triangle_plane_equation.sv =====
// Top level: vertex store and streaming plane-equation pipeline.
//
// Usage
//   One request channel (in_*) carries two kinds of request: a vertex load
//   (in_op = load) writes three Q16.16 coordinates to in_vertex_slot and
//   gives no result; a face (in_op = face) names three store entries and
//   gives one result on the out_* channel: the Q2.30 unit normal, the
//   Q16.16 plane offset, a degenerate flag and a copy of in_face_last.
//   Both channels are valid/ready.
// Throughput and pipeline
//   One request per cycle while the output is not stalled, loads and
//   faces mixed freely. A face result passes through the store read,
//   nine arithmetic stages, 32 square-root stages, 31 divider stages,
//   three stages of sign, products and dot sum, and the output register,
//   which also takes the rounded, saturated plane offset.
//   A load takes effect at its own acceptance edge, so a face accepted in
//   the very next cycle already reads the new vertex.
// Stall
//   The whole pipeline advances together. It holds only while the output
//   register holds a result that the receiver has not taken; in_ready
//   drops in exactly those cycles.
// Reset
//   rst_n clears every stage valid and the output valid. The vertex
//   store is not cleared; load every vertex before a face names it.
module indexed_triangle_plane_equation (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_op,
  input  logic [11:0] in_vertex_slot,
  input  logic signed [31:0] in_coord_x,
  input  logic signed [31:0] in_coord_y,
  input  logic signed [31:0] in_coord_z,
  input  logic [11:0] in_corner_a,
  input  logic [11:0] in_corner_b,
  input  logic [11:0] in_corner_c,
  input  logic        in_face_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] out_normal_x,
  output logic signed [31:0] out_normal_y,
  output logic signed [31:0] out_normal_z,
  output logic signed [31:0] out_plane_offset,
  output logic        out_degenerate,
  output logic        out_plane_last
);

  localparam int EW = tpe_pkg::EDGE_W;
  localparam int PW = tpe_pkg::PROD_W;
  localparam int CW = tpe_pkg::CROSS_W;
  localparam int MW = tpe_pkg::MAG_W;

  logic adv;
  logic accept;
  logic out_valid_r;

  // Advance everything unless a finished result is waiting.
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;
  assign accept   = in_valid && in_ready;

  // ---------------------------------------------------------------------
  // Vertex store: three copies, one read port per corner, all written on
  // every load.
  // ---------------------------------------------------------------------
  logic [11:0] corner [3];
  logic [tpe_pkg::VERT_W-1:0] rd_data [3];
  logic load_we;

  assign corner[0] = in_corner_a;
  assign corner[1] = in_corner_b;
  assign corner[2] = in_corner_c;

  assign load_we = accept && (in_op == tpe_pkg::OP_LOAD) &&
                   (32'(in_vertex_slot) < 32'(tpe_pkg::VERTEX_DEPTH));

  for (genvar v = 0; v < 3; v++) begin : g_store
    tpe_ram #(
      .WIDTH (tpe_pkg::VERT_W),
      .DEPTH (tpe_pkg::VERTEX_DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (load_we),
      .waddr (tpe_pkg::addr_t'(in_vertex_slot)),
      .wdata ({in_coord_z, in_coord_y, in_coord_x}),
      .re    (adv),
      .raddr (tpe_pkg::addr_t'(corner[v])),
      .rdata (rd_data[v])
    );
  end

  // Stage 1: read issued, remember which corners lie inside the store.
  tpe_pkg::side_t s1_side_r;
  logic [2:0] s1_inr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_side_r.vld <= 1'b0;
    end else if (adv) begin
      s1_side_r.vld <= accept && (in_op == tpe_pkg::OP_FACE);
    end
    if (adv) begin
      s1_side_r.last  <= in_face_last;
      s1_side_r.degen <= 1'b0;
      s1_side_r.neg   <= '0;
      s1_side_r.ax    <= '0;
      s1_side_r.ay    <= '0;
      s1_side_r.az    <= '0;
      for (int v = 0; v < 3; v++) begin
        s1_inr_r[v] <= 32'(corner[v]) < 32'(tpe_pkg::VERTEX_DEPTH);
      end
    end
  end

  // Stage 2: edge vectors e1 = a - b, e2 = a - c, exact in 33 bits.
  tpe_pkg::coord_t vtx [3][3];
  tpe_pkg::side_t  s2_side_r, s2_side_nxt;
  logic signed [EW-1:0] e1_r [3], e2_r [3], e1_nxt [3], e2_nxt [3];

  always_comb begin
    for (int v = 0; v < 3; v++) begin
      for (int k = 0; k < 3; k++) begin
        vtx[v][k] = s1_inr_r[v] ? rd_data[v][k*tpe_pkg::COORD_W +: tpe_pkg::COORD_W] : '0;
      end
    end
    s2_side_nxt    = s1_side_r;
    s2_side_nxt.ax = vtx[0][0];
    s2_side_nxt.ay = vtx[0][1];
    s2_side_nxt.az = vtx[0][2];
    for (int k = 0; k < 3; k++) begin
      e1_nxt[k] = EW'(vtx[0][k]) - EW'(vtx[1][k]);
      e2_nxt[k] = EW'(vtx[0][k]) - EW'(vtx[2][k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_side_r.vld <= 1'b0;
    end else if (adv) begin
      s2_side_r <= s2_side_nxt;
    end
    if (adv) begin
      e1_r <= e1_nxt;
      e2_r <= e2_nxt;
    end
  end

  // Stage 3: the six partial products of the cross product.
  tpe_pkg::side_t s3_side_r;
  logic signed [PW-1:0] p_r [6], p_nxt [6];

  always_comb begin
    p_nxt[0] = e1_r[1] * e2_r[2];
    p_nxt[1] = e1_r[2] * e2_r[1];
    p_nxt[2] = e1_r[2] * e2_r[0];
    p_nxt[3] = e1_r[0] * e2_r[2];
    p_nxt[4] = e1_r[0] * e2_r[1];
    p_nxt[5] = e1_r[1] * e2_r[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_side_r.vld <= 1'b0;
    end else if (adv) begin
      s3_side_r <= s2_side_r;
    end
    if (adv) begin
      p_r <= p_nxt;
    end
  end

  // Stage 4: cross product components, exact in 67 bits.
  tpe_pkg::side_t s4_side_r;
  logic signed [CW-1:0] c_r [3], c_nxt [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      c_nxt[i] = CW'(p_r[2*i]) - CW'(p_r[2*i+1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_side_r.vld <= 1'b0;
    end else if (adv) begin
      s4_side_r <= s3_side_r;
    end
    if (adv) begin
      c_r <= c_nxt;
    end
  end

  // Stage 5: split into sign and magnitude.
  tpe_pkg::side_t s5_side_r, s5_side_nxt;
  logic [MW-1:0] mag5_r [3], mag5_nxt [3];

  always_comb begin
    s5_side_nxt = s4_side_r;
    for (int i = 0; i < 3; i++) begin
      s5_side_nxt.neg[i] = c_r[i][CW-1];
      mag5_nxt[i] = c_r[i][CW-1] ? MW'(-c_r[i]) : MW'(c_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_side_r.vld <= 1'b0;
    end else if (adv) begin
      s5_side_r <= s5_side_nxt;
    end
    if (adv) begin
      mag5_r <= mag5_nxt;
    end
  end

  // Stage 6: bit length of each byte of the OR of the magnitudes.
  tpe_pkg::side_t s6_side_r;
  logic [MW-1:0] mag6_r [3];
  logic [tpe_pkg::CLEN_W-1:0] clen_r [tpe_pkg::NCHUNK], clen_nxt [tpe_pkg::NCHUNK];
  logic [tpe_pkg::NCHUNK*tpe_pkg::CHUNK_W-1:0] mag_or;

  always_comb begin
    mag_or = (tpe_pkg::NCHUNK*tpe_pkg::CHUNK_W)'(mag5_r[0] | mag5_r[1] | mag5_r[2]);
    for (int j = 0; j < tpe_pkg::NCHUNK; j++) begin
      clen_nxt[j] = '0;
      for (int b = 0; b < tpe_pkg::CHUNK_W; b++) begin
        if (mag_or[j*tpe_pkg::CHUNK_W + b]) begin
          clen_nxt[j] = tpe_pkg::CLEN_W'(b + 1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_side_r.vld <= 1'b0;
    end else if (adv) begin
      s6_side_r <= s5_side_r;
    end
    if (adv) begin
      mag6_r <= mag5_r;
      clen_r <= clen_nxt;
    end
  end

  // Stage 7: largest bit length L; a zero cross product has L = 0.
  tpe_pkg::side_t s7_side_r, s7_side_nxt;
  logic [MW-1:0] mag7_r [3];
  logic [tpe_pkg::LEN_W-1:0] len_r, len_nxt;

  always_comb begin
    len_nxt = '0;
    for (int j = 0; j < tpe_pkg::NCHUNK; j++) begin
      if (clen_r[j] != '0) begin
        len_nxt = tpe_pkg::LEN_W'(j * tpe_pkg::CHUNK_W) + tpe_pkg::LEN_W'(clen_r[j]);
      end
    end
    s7_side_nxt       = s6_side_r;
    s7_side_nxt.degen = (len_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_side_r.vld <= 1'b0;
    end else if (adv) begin
      s7_side_r <= s7_side_nxt;
    end
    if (adv) begin
      mag7_r <= mag6_r;
      len_r  <= len_nxt;
    end
  end

  // Stage 8: block scaling so the largest magnitude lies in [2^29, 2^30).
  tpe_pkg::side_t   s8_side_r;
  tpe_pkg::sc_vec_t sc8_r, sc8_nxt;
  logic [tpe_pkg::SHF_W-1:0] shf [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      shf[i]     = (tpe_pkg::SHF_W'(mag7_r[i]) << tpe_pkg::SC_W) >> len_r;
      sc8_nxt[i] = shf[i][tpe_pkg::SC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s8_side_r.vld <= 1'b0;
    end else if (adv) begin
      s8_side_r <= s7_side_r;
    end
    if (adv) begin
      sc8_r <= sc8_nxt;
    end
  end

  // Stage 9: squares.
  tpe_pkg::side_t   s9_side_r;
  tpe_pkg::sc_vec_t sc9_r;
  logic [tpe_pkg::SQ_W-1:0] sq_r [3], sq_nxt [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_nxt[i] = tpe_pkg::SQ_W'(sc8_r[i]) * tpe_pkg::SQ_W'(sc8_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s9_side_r.vld <= 1'b0;
    end else if (adv) begin
      s9_side_r <= s8_side_r;
    end
    if (adv) begin
      sc9_r <= sc8_r;
      sq_r  <= sq_nxt;
    end
  end

  // Stage 10: sum of squares.
  tpe_pkg::side_t   s10_side_r;
  tpe_pkg::sc_vec_t sc10_r;
  logic [tpe_pkg::SUM_W-1:0] sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s10_side_r.vld <= 1'b0;
    end else if (adv) begin
      s10_side_r <= s9_side_r;
    end
    if (adv) begin
      sc10_r <= sc9_r;
      sum_r  <= tpe_pkg::SUM_W'(sq_r[0]) + tpe_pkg::SUM_W'(sq_r[1]) +
                tpe_pkg::SUM_W'(sq_r[2]);
    end
  end

  // Square root and division.
  tpe_pkg::side_t    sq_side, dv_side;
  tpe_pkg::sc_vec_t  sq_sc;
  tpe_pkg::quo_vec_t dv_quo;
  logic [tpe_pkg::ROOT_W-1:0] sq_root;

  tpe_isqrt u_isqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (adv),
    .side_i (s10_side_r),
    .sc_i   (sc10_r),
    .sum_i  (sum_r),
    .side_o (sq_side),
    .sc_o   (sq_sc),
    .root_o (sq_root)
  );

  tpe_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (adv),
    .side_i (sq_side),
    .sc_i   (sq_sc),
    .root_i (sq_root),
    .side_o (dv_side),
    .quo_o  (dv_quo)
  );

  // Signed normal; a degenerate face gives zeros.
  tpe_pkg::side_t n_side_r;
  logic signed [tpe_pkg::NRM_W-1:0] n_r [3], n_nxt [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dv_side.degen) begin
        n_nxt[i] = '0;
      end else if (dv_side.neg[i]) begin
        n_nxt[i] = -tpe_pkg::NRM_W'(dv_quo[i]);
      end else begin
        n_nxt[i] = tpe_pkg::NRM_W'(dv_quo[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_side_r.vld <= 1'b0;
    end else if (adv) begin
      n_side_r <= dv_side;
    end
    if (adv) begin
      n_r <= n_nxt;
    end
  end

  // Products of the normal with the reference vertex.
  tpe_pkg::side_t dp_side_r;
  logic signed [tpe_pkg::NRM_W-1:0] nd_r [3];
  logic signed [tpe_pkg::DP_W-1:0]  dp_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dp_side_r.vld <= 1'b0;
    end else if (adv) begin
      dp_side_r <= n_side_r;
    end
    if (adv) begin
      nd_r    <= n_r;
      dp_r[0] <= n_r[0] * n_side_r.ax;
      dp_r[1] <= n_r[1] * n_side_r.ay;
      dp_r[2] <= n_r[2] * n_side_r.az;
    end
  end

  // Dot product.
  tpe_pkg::side_t dot_side_r;
  logic signed [tpe_pkg::NRM_W-1:0] ndot_r [3];
  logic signed [tpe_pkg::DOT_W-1:0] dot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_side_r.vld <= 1'b0;
    end else if (adv) begin
      dot_side_r <= dp_side_r;
    end
    if (adv) begin
      ndot_r <= nd_r;
      dot_r  <= tpe_pkg::DOT_W'(dp_r[0]) + tpe_pkg::DOT_W'(dp_r[1]) +
                tpe_pkg::DOT_W'(dp_r[2]);
    end
  end

  // Plane offset: round -dot from Q20.46 to Q16.16 and saturate.
  logic signed [tpe_pkg::FIN_W-1:0] ofs_p, ofs_q;
  logic signed [31:0] ofs_fin;

  always_comb begin
    ofs_p = tpe_pkg::OFS_HALF - tpe_pkg::FIN_W'(dot_r);
    ofs_q = ofs_p >>> tpe_pkg::SC_W;
    if (dot_side_r.degen) begin
      ofs_fin = '0;
    end else if (ofs_q > tpe_pkg::OFS_MAX) begin
      ofs_fin = tpe_pkg::OFS_MAX[31:0];
    end else if (ofs_q < tpe_pkg::OFS_MIN) begin
      ofs_fin = tpe_pkg::OFS_MIN[31:0];
    end else begin
      ofs_fin = ofs_q[31:0];
    end
  end

  // Output register: holds while the receiver stalls.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dot_side_r.vld;
    end
    if (adv) begin
      out_normal_x     <= ndot_r[0];
      out_normal_y     <= ndot_r[1];
      out_normal_z     <= ndot_r[2];
      out_plane_offset <= ofs_fin;
      out_degenerate   <= dot_side_r.degen;
      out_plane_last   <= dot_side_r.last;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== rtl/tpe_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tpe_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/tpe_isqrt.sv =====
// Pipelined bitwise integer square root, one result bit per stage.
module tpe_isqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  tpe_pkg::side_t              side_i,
  input  tpe_pkg::sc_vec_t            sc_i,
  input  logic [tpe_pkg::SUM_W-1:0]   sum_i,
  output tpe_pkg::side_t              side_o,
  output tpe_pkg::sc_vec_t            sc_o,
  output logic [tpe_pkg::ROOT_W-1:0]  root_o
);

  localparam int N = tpe_pkg::ISQRT_STEPS;
  localparam int W = tpe_pkg::SQRT_W;

  tpe_pkg::side_t   side_r [N];
  tpe_pkg::sc_vec_t sc_r   [N];
  logic [W-1:0]     v_r    [N];
  logic [W-1:0]     res_r  [N];

  for (genvar k = 0; k < N; k++) begin : g_step
    localparam logic [W-1:0] BIT = W'(1) << (W - 2 - 2 * k);
    tpe_pkg::side_t   side_in;
    tpe_pkg::sc_vec_t sc_in;
    logic [W-1:0]     v_in, res_in, trial, v_nxt, res_nxt;

    if (k == 0) begin : g_first
      assign side_in = side_i;
      assign sc_in   = sc_i;
      assign v_in    = W'(sum_i);
      assign res_in  = '0;
    end else begin : g_next
      assign side_in = side_r[k-1];
      assign sc_in   = sc_r[k-1];
      assign v_in    = v_r[k-1];
      assign res_in  = res_r[k-1];
    end

    always_comb begin
      trial = res_in + BIT;
      if (v_in >= trial) begin
        v_nxt   = v_in - trial;
        res_nxt = (res_in >> 1) + BIT;
      end else begin
        v_nxt   = v_in;
        res_nxt = res_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        side_r[k].vld <= 1'b0;
      end else if (en) begin
        side_r[k] <= side_in;
      end
      if (en) begin
        sc_r[k]  <= sc_in;
        v_r[k]   <= v_nxt;
        res_r[k] <= res_nxt;
      end
    end
  end

  assign side_o = side_r[N-1];
  assign sc_o   = sc_r[N-1];
  assign root_o = res_r[N-1][tpe_pkg::ROOT_W-1:0];

endmodule

// ===== rtl/tpe_div.sv =====
// Pipelined restoring divider, three lanes sharing one divisor, one quotient bit per stage.
module tpe_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  tpe_pkg::side_t              side_i,
  input  tpe_pkg::sc_vec_t            sc_i,
  input  logic [tpe_pkg::ROOT_W-1:0]  root_i,
  output tpe_pkg::side_t              side_o,
  output tpe_pkg::quo_vec_t           quo_o
);

  localparam int N  = tpe_pkg::QUO_W;
  localparam int RW = tpe_pkg::REM_W;

  tpe_pkg::side_t    side_r [N];
  tpe_pkg::rem_vec_t rem_r  [N];
  tpe_pkg::quo_vec_t quo_r  [N];
  logic [tpe_pkg::ROOT_W-1:0] div_r [N];

  for (genvar k = 0; k < N; k++) begin : g_step
    localparam int POS = N - 1 - k;
    tpe_pkg::side_t    side_in;
    tpe_pkg::rem_vec_t rem_in, rem_nxt;
    tpe_pkg::quo_vec_t quo_in, quo_nxt;
    logic [tpe_pkg::ROOT_W-1:0] div_in;
    logic [RW-1:0] dsh;

    if (k == 0) begin : g_first
      // Force a nonzero divisor; round to nearest by adding half the divisor.
      always_comb begin
        side_in = side_i;
        div_in  = (root_i == '0) ? tpe_pkg::ROOT_W'(1) : root_i;
        quo_in  = '0;
        for (int i = 0; i < 3; i++) begin
          rem_in[i] = (RW'(sc_i[i]) << tpe_pkg::SC_W) + RW'(div_in >> 1);
        end
      end
    end else begin : g_next
      assign side_in = side_r[k-1];
      assign div_in  = div_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign quo_in  = quo_r[k-1];
    end

    always_comb begin
      dsh     = RW'(div_in) << POS;
      rem_nxt = rem_in;
      quo_nxt = quo_in;
      for (int i = 0; i < 3; i++) begin
        if (rem_in[i] >= dsh) begin
          rem_nxt[i]      = rem_in[i] - dsh;
          quo_nxt[i][POS] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        side_r[k].vld <= 1'b0;
      end else if (en) begin
        side_r[k] <= side_in;
      end
      if (en) begin
        rem_r[k] <= rem_nxt;
        quo_r[k] <= quo_nxt;
        div_r[k] <= div_in;
      end
    end
  end

  assign side_o = side_r[N-1];
  assign quo_o  = quo_r[N-1];

endmodule

// ===== rtl/tpe_checker.sv =====
// Port-level checks for the triangle plane equation block, bound to the top level.
module tpe_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic signed [31:0] out_normal_x,
  input logic signed [31:0] out_normal_y,
  input logic signed [31:0] out_normal_z,
  input logic signed [31:0] out_plane_offset,
  input logic        out_degenerate,
  input logic        out_plane_last
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_normal_x) &&
    $stable(out_normal_y) && $stable(out_normal_z) &&
    $stable(out_plane_offset) && $stable(out_degenerate) && $stable(out_plane_last))
    else $error("stalled result changed");

  // Requests are refused only while a result waits.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("in_ready low without output stall");

  // Degenerate faces give all-zero plane.
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> out_normal_x == 0 && out_normal_y == 0 &&
    out_normal_z == 0 && out_plane_offset == 0)
    else $error("degenerate face with nonzero plane");

  // Normal components stay within unit range.
  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_normal_x <= 32'sd1073741824 && out_normal_x >= -32'sd1073741824 &&
    out_normal_y <= 32'sd1073741824 && out_normal_y >= -32'sd1073741824 &&
    out_normal_z <= 32'sd1073741824 && out_normal_z >= -32'sd1073741824)
    else $error("normal component out of range");

endmodule

bind indexed_triangle_plane_equation tpe_checker u_tpe_checker (.*);
